/* design/nrhc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrhc_pkg: shared types, tables and helpers for the nibble rotor hex cipher
// Substitution tables, hex character conversion, register indexes and the
// result bundle passed from the cipher core to the output buffer.
// ----------------------------------------------------------------------------
package nrhc_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int KEY_W      = 32;
    localparam int CHAR_W     = 8;
    localparam int NIB_W      = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 1'b0,
        CFG_KEY_START = 1'b1
    } cfg_index_t;

    // Operating modes
    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // One result item
    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              bad_hex;
        logic              out_last;
    } result_t;

    // Forward and inverse substitution tables
    localparam logic [NIB_W-1:0] SBOX_A [16] = '{
        4'hb, 4'hd, 4'h2, 4'hf, 4'ha, 4'h0, 4'h5, 4'h3,
        4'h4, 4'h8, 4'he, 4'hc, 4'h1, 4'h9, 4'h7, 4'h6
    };
    localparam logic [NIB_W-1:0] SBOX_B [16] = '{
        4'h2, 4'hc, 4'h5, 4'hf, 4'ha, 4'h3, 4'h8, 4'h0,
        4'hd, 4'h1, 4'he, 4'hb, 4'h4, 4'h7, 4'h9, 4'h6
    };
    localparam logic [NIB_W-1:0] INV_A [16] = '{
        4'h5, 4'hc, 4'h2, 4'h7, 4'h8, 4'h6, 4'hf, 4'he,
        4'h9, 4'hd, 4'h4, 4'h0, 4'hb, 4'h1, 4'ha, 4'h3
    };
    localparam logic [NIB_W-1:0] INV_B [16] = '{
        4'h7, 4'h9, 4'h0, 4'h5, 4'hc, 4'h2, 4'hf, 4'hd,
        4'h6, 4'he, 4'h4, 4'hb, 4'h1, 4'h8, 4'ha, 4'h3
    };

    localparam logic [CHAR_W-1:0] ASCII_0       = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_9       = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_A_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_F_LOWER = 8'h66;
    // 'a' minus ten
    localparam logic [CHAR_W-1:0] ASCII_A_OFS   = 8'h57;

    // Nibble to lower-case hex character
    function automatic logic [CHAR_W-1:0] nib_to_hex(input logic [NIB_W-1:0] n);
        logic [CHAR_W-1:0] n_ext;
        n_ext = {{(CHAR_W-NIB_W){1'b0}}, n};
        if (n < 4'd10) begin
            return ASCII_0 + n_ext;
        end else begin
            return ASCII_A_OFS + n_ext;
        end
    endfunction

    // Forward two-stage substitution of one nibble under key byte k
    function automatic logic [NIB_W-1:0] enc_nib(input logic [NIB_W-1:0] n,
                                                 input logic [7:0]       k);
        logic [NIB_W-1:0] t;
        logic [NIB_W-1:0] u;
        t = n + k[3:0];
        u = SBOX_A[t] + k[7:4];
        return SBOX_B[u];
    endfunction

    // Inverse two-stage substitution of one nibble under key byte k
    function automatic logic [NIB_W-1:0] dec_nib(input logic [NIB_W-1:0] n,
                                                 input logic [7:0]       k);
        logic [NIB_W-1:0] t;
        logic [NIB_W-1:0] u;
        t = INV_B[n] - k[7:4];
        u = INV_A[t] - k[3:0];
        return u;
    endfunction

endpackage

/* design/nrhc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrhc_core: cipher datapath and running state
// Holds the key counter and the pending decode nibble; turns one item into
// zero, one or two results in a single combinational pass.
// ----------------------------------------------------------------------------
module nrhc_core
    import nrhc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   mode,
    input  logic [KEY_W-1:0]       key_start,
    input  logic                   item_fire,
    input  logic [CHAR_W-1:0]      char_in,
    input  logic                   start_req,
    output logic [1:0]             res_count,
    output result_t                res0,
    output result_t                res1
);

    logic [KEY_W-1:0]  key_counter_reg, key_counter_next;
    logic [NIB_W-1:0]  pending_nibble_reg, pending_nibble_next;
    logic              pending_valid_reg, pending_valid_next;
    logic              pending_bad_reg, pending_bad_next;

    logic [KEY_W-1:0]  key_eff;
    logic [7:0]        key_hi_byte;
    logic              pend_valid_eff;
    logic [NIB_W-1:0]  pend_nib_eff;
    logic              pend_bad_eff;
    logic [NIB_W-1:0]  enc_lo;
    logic [NIB_W-1:0]  enc_hi;
    logic [NIB_W-1:0]  hex_val;
    logic              hex_bad;
    logic [NIB_W-1:0]  dec_n;

    // Start request reloads the key and drops the pending nibble
    always_comb begin
        key_eff        = start_req ? key_start : key_counter_reg;
        pend_valid_eff = start_req ? 1'b0 : pending_valid_reg;
        pend_nib_eff   = start_req ? '0   : pending_nibble_reg;
        pend_bad_eff   = start_req ? 1'b0 : pending_bad_reg;
        key_hi_byte    = key_eff[7:0] + 8'd1;
    end

    // Encode: low nibble under key, high nibble under key + 1
    always_comb begin
        enc_lo = enc_nib(char_in[3:0], key_eff[7:0]);
        enc_hi = enc_nib(char_in[7:4], key_hi_byte);
    end

    // Decode: hex character to value, then inverse chain
    always_comb begin
        hex_val = '0;
        hex_bad = 1'b0;
        if (char_in >= ASCII_0 && char_in <= ASCII_9) begin
            hex_val = NIB_W'(char_in - ASCII_0);
        end else if (char_in >= ASCII_A_LOWER && char_in <= ASCII_F_LOWER) begin
            hex_val = NIB_W'(char_in - ASCII_A_OFS);
        end else begin
            hex_bad = 1'b1;
        end
        dec_n = dec_nib(hex_val, key_eff[7:0]);
    end

    // Results and next state
    always_comb begin
        res0                = '0;
        res1                = '0;
        res_count           = 2'd0;
        key_counter_next    = key_counter_reg;
        pending_nibble_next = pending_nibble_reg;
        pending_valid_next  = pending_valid_reg;
        pending_bad_next    = pending_bad_reg;
        if (mode == MODE_ENCODE) begin
            res0.char_out       = nib_to_hex(enc_lo);
            res1.char_out       = nib_to_hex(enc_hi);
            res1.out_last       = 1'b1;
            res_count           = 2'd2;
            key_counter_next    = key_eff + KEY_W'(2);
            pending_nibble_next = pend_nib_eff;
            pending_valid_next  = pend_valid_eff;
            pending_bad_next    = pend_bad_eff;
        end else begin
            key_counter_next = key_eff + KEY_W'(1);
            if (!pend_valid_eff) begin
                pending_nibble_next = dec_n;
                pending_valid_next  = 1'b1;
                pending_bad_next    = hex_bad;
            end else begin
                res0.char_out       = {dec_n, pend_nib_eff};
                res0.bad_hex        = pend_bad_eff | hex_bad;
                res0.out_last       = 1'b1;
                res_count           = 2'd1;
                pending_nibble_next = '0;
                pending_valid_next  = 1'b0;
                pending_bad_next    = 1'b0;
            end
        end
    end

    // State registers, updated once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_counter_reg    <= '0;
            pending_nibble_reg <= '0;
            pending_valid_reg  <= 1'b0;
            pending_bad_reg    <= 1'b0;
        end else if (item_fire) begin
            key_counter_reg    <= key_counter_next;
            pending_nibble_reg <= pending_nibble_next;
            pending_valid_reg  <= pending_valid_next;
            pending_bad_reg    <= pending_bad_next;
        end
    end

endmodule

/* design/nrhc_obuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrhc_obuf: two-entry result buffer
// Loads up to two results at once and drains them one per handshake.
// ----------------------------------------------------------------------------
module nrhc_obuf
    import nrhc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic [1:0]    load_count,
    input  result_t       load_res0,
    input  result_t       load_res1,
    output logic          can_load,
    output logic          m_valid,
    input  logic          m_ready,
    output result_t       m_res
);

    logic [1:0] count_reg, count_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       drain;

    assign drain    = m_valid & m_ready;
    // Loading is allowed once the buffer empties in this cycle
    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign m_valid  = (count_reg != 2'd0);
    assign m_res    = head_reg;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (load) begin
            count_next = load_count;
            head_next  = load_res0;
            tail_next  = load_res1;
        end else if (drain) begin
            count_next = count_reg - 2'd1;
            head_next  = tail_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

/* design/nibble_rotor_hex_cipher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_rotor_hex_cipher_top: stepping nibble substitution cipher
// Encodes bytes to pairs of hex characters or decodes hex characters back
// to bytes under a running key counter.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | s_valid s_ready s_char_in s_start_req   | in
//   result  | m_valid m_ready m_char_out m_bad_hex    | out
//           | m_out_last                              |
//   config  | cfg_we cfg_index cfg_wdata              | in
//
// An item sits in the input register, goes through combinational cipher logic
// and lands in a two-entry result buffer, which drains one result per cycle
// while m_ready is high and so paces encode; decode gives one byte per two
// hex characters. Each result passes the input register, then the buffer.
// Reset clears the key counter, pending nibble, mode and key_start.
// A stalled result side fills the buffer and then the input register.
// ----------------------------------------------------------------------------
module nibble_rotor_hex_cipher_top
    import nrhc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAR_W-1:0]     s_char_in,
    input  logic                  s_start_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_W-1:0]     m_char_out,
    output logic                  m_bad_hex,
    output logic                  m_out_last
);

    logic              mode_reg;
    logic [KEY_W-1:0]  key_start_reg;
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_start_reg;
    logic              can_load;
    logic              move;
    logic [1:0]        res_count;
    result_t           res0;
    result_t           res1;
    result_t           m_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_ENCODE;
            key_start_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:      mode_reg      <= cfg_wdata[0];
                CFG_KEY_START: key_start_reg <= cfg_wdata[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: an item moves on when the result buffer can take it
    assign move    = in_valid_reg & can_load;
    assign s_ready = ~in_valid_reg | move;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (move) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg  <= s_char_in;
            in_start_reg <= s_start_req;
        end
    end

    nrhc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .key_start (key_start_reg),
        .item_fire (move),
        .char_in   (in_char_reg),
        .start_req (in_start_reg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    nrhc_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (move),
        .load_count (res_count),
        .load_res0  (res0),
        .load_res1  (res1),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_char_out = m_res.char_out;
    assign m_bad_hex  = m_res.bad_hex;
    assign m_out_last = m_res.out_last;

endmodule
